// ===== rtl/core/gabd_pkg.sv =====
// Grid argmax box decoder: shared types, constants and register indexes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package gabd_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_IN_OFFSET   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCORE_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_SCORE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CELL_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CELL_HEIGHT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_X     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_Y     = 3'd6;

  // Register reset values
  localparam logic [7:0]  ZeroPointRst  = 8'd0;
  localparam logic [23:0] ScoreGainRst  = 24'd65536;
  localparam logic [7:0]  ThresholdRst  = 8'd50;
  localparam logic [7:0]  CellWidthRst  = 8'd8;
  localparam logic [7:0]  CellHeightRst = 8'd8;
  localparam logic [15:0] ScaleXRst     = 16'd256;
  localparam logic [15:0] ScaleYRst     = 16'd256;

  // Job queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic signed [7:0] in_offset;
    logic [23:0]       score_gain;
    logic [7:0]        min_score;
    logic [7:0]        cell_width;
    logic [7:0]        cell_height;
    logic [15:0]       scale_x;
    logic [15:0]       scale_y;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] raw_score;
    logic              cell_end;
    logic              row_end;
    logic              frame_end;
  } score_t;

  typedef struct packed {
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [7:0]  box_score;
    logic [7:0]  box_class;
  } box_t;

  // One detected cell, handed from front to back
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] score;
    logic [7:0] cls;
  } job_t;

endpackage

// ===== rtl/core/grid_argmax_box_decoder_unit.sv =====
// Grid argmax box decoder top level: configuration registers, front, job
// queue and back. Depends on gabd_pkg, gabd_front, gabd_queue, gabd_back.
// Throughput: one score per cycle and, while out_ready_i is high, up to one box per cycle; the input
//   stalls only while the two-entry job queue is full.
// Path: a box reaches out_valid_o from the queue write of the cell's last
//   score through the back's stage-1 register and then its output register.
// Reset: rst_ni clears all control state and loads the register defaults.
`timescale 1ns / 1ps
module grid_argmax_box_decoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  gabd_pkg::score_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output gabd_pkg::box_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [gabd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gabd_pkg::CfgDataW-1:0]    cfg_data_i
);
  import gabd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic full, empty, push, pop;
  job_t push_data, pop_data;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_OFFSET:   cfg_d.in_offset   = cfg_data_i[7:0];
        CFG_SCORE_GAIN:  cfg_d.score_gain  = cfg_data_i;
        CFG_MIN_SCORE:   cfg_d.min_score   = cfg_data_i[7:0];
        CFG_CELL_WIDTH:  cfg_d.cell_width  = cfg_data_i[7:0];
        CFG_CELL_HEIGHT: cfg_d.cell_height = cfg_data_i[7:0];
        CFG_SCALE_X:     cfg_d.scale_x     = cfg_data_i[15:0];
        CFG_SCALE_Y:     cfg_d.scale_y     = cfg_data_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_offset   <= ZeroPointRst;
      cfg_q.score_gain  <= ScoreGainRst;
      cfg_q.min_score   <= ThresholdRst;
      cfg_q.cell_width  <= CellWidthRst;
      cfg_q.cell_height <= CellHeightRst;
      cfg_q.scale_x     <= ScaleXRst;
      cfg_q.scale_y     <= ScaleYRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gabd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  gabd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty),
    .full_o      (full)
  );

  gabd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .job_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/gabd_front.sv =====
// Front part: dequantizes scores, keeps the per-cell argmax and grid position,
// and queues one job per detected cell. Depends on gabd_pkg.
`timescale 1ns / 1ps
module gabd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gabd_pkg::score_t in_data_i,
  input  gabd_pkg::cfg_t   cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output gabd_pkg::job_t   push_data_o
);
  import gabd_pkg::*;

  logic [7:0] class_cnt_q, class_cnt_d;
  logic [7:0] best_score_q, best_score_d;
  logic [7:0] best_class_q, best_class_d;
  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;

  logic              accept;
  logic signed [8:0] diff;
  logic [31:0]       prod;
  logic [7:0]        score;
  logic [7:0]        new_score;
  logic [7:0]        new_class;
  logic              hit;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Dequantize: ((q - offset) * gain) >> 16, clamped to 0..255
  always_comb begin
    diff = $signed({in_data_i.raw_score[7], in_data_i.raw_score})
         - $signed({cfg_i.in_offset[7], cfg_i.in_offset});
    prod = {24'd0, diff[7:0]} * {8'd0, cfg_i.score_gain};
    if (diff[8] || (diff == 9'sd0)) begin
      score = 8'd0;
    end else if (prod[31:24] != 8'd0) begin
      score = 8'hff;
    end else begin
      score = prod[23:16];
    end
  end

  // Strict argmax, earlier class wins ties
  always_comb begin
    if (score > best_score_q) begin
      new_score = score;
      new_class = class_cnt_q;
    end else begin
      new_score = best_score_q;
      new_class = best_class_q;
    end
    hit = (new_score > cfg_i.min_score) && (new_class != 8'd0);
  end

  assign push_o            = accept && in_data_i.cell_end && hit;
  assign push_data_o.col   = col_q;
  assign push_data_o.row   = row_q;
  assign push_data_o.score = new_score;
  assign push_data_o.cls   = new_class;

  // Cell and grid bookkeeping
  always_comb begin
    class_cnt_d  = class_cnt_q;
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    col_d        = col_q;
    row_d        = row_q;
    if (accept) begin
      if (in_data_i.cell_end) begin
        class_cnt_d  = 8'd0;
        best_score_d = 8'd0;
        best_class_d = 8'd0;
        if (in_data_i.frame_end) begin
          col_d = 8'd0;
          row_d = 8'd0;
        end else if (in_data_i.row_end) begin
          col_d = 8'd0;
          row_d = row_q + 8'd1;
        end else begin
          col_d = col_q + 8'd1;
        end
      end else begin
        class_cnt_d  = class_cnt_q + 8'd1;
        best_score_d = new_score;
        best_class_d = new_class;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_cnt_q  <= 8'd0;
      best_score_q <= 8'd0;
      best_class_q <= 8'd0;
      col_q        <= 8'd0;
      row_q        <= 8'd0;
    end else begin
      class_cnt_q  <= class_cnt_d;
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
      col_q        <= col_d;
      row_q        <= row_d;
    end
  end

endmodule

// ===== rtl/core/gabd_queue.sv =====
// Short job queue that decouples the front from the back.
// Depends on gabd_pkg.
`timescale 1ns / 1ps
module gabd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gabd_pkg::job_t push_data_i,
  input  logic          pop_i,
  output gabd_pkg::job_t pop_data_o,
  output logic          empty_o,
  output logic          full_o
);
  import gabd_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == QueueCntW'(QueueDepth));
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/gabd_back.sv =====
// Back part: turns a queued cell job into a scaled box over two pipeline
// stages with an output register. Depends on gabd_pkg.
`timescale 1ns / 1ps
module gabd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gabd_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  gabd_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gabd_pkg::box_t out_data_o
);
  import gabd_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [15:0] cx_q, cy_q;
  logic [15:0] w_q, h_q;
  logic [7:0]  score_q, cls_q;
  logic        out_valid_q, out_valid_d;
  box_t        out_q;

  logic        s1_en, s2_en;
  logic [15:0] cx, cy;
  logic [23:0] w_prod, h_prod;
  logic [31:0] x_prod, y_prod;

  assign s2_en = !out_valid_q || out_ready_i;
  assign s1_en = !s1_valid_q || s2_en;
  assign pop_o = !empty_i && s1_en;

  // Stage 1: cell centre in model pixels, scaled cell size
  always_comb begin
    cx     = ({8'd0, job_i.col} * {8'd0, cfg_i.cell_width}) + {9'd0, cfg_i.cell_width[7:1]};
    cy     = ({8'd0, job_i.row} * {8'd0, cfg_i.cell_height}) + {9'd0, cfg_i.cell_height[7:1]};
    w_prod = {16'd0, cfg_i.cell_width} * {8'd0, cfg_i.scale_x};
    h_prod = {16'd0, cfg_i.cell_height} * {8'd0, cfg_i.scale_y};
  end

  // Stage 2: scale the centre, saturate to 16 bits
  always_comb begin
    x_prod = {16'd0, cx_q} * {16'd0, cfg_i.scale_x};
    y_prod = {16'd0, cy_q} * {16'd0, cfg_i.scale_y};
  end

  always_comb begin
    s1_valid_d  = s1_en ? !empty_i : s1_valid_q;
    out_valid_d = s2_en ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      cx_q    <= cx;
      cy_q    <= cy;
      w_q     <= w_prod[23:8];
      h_q     <= h_prod[23:8];
      score_q <= job_i.score;
      cls_q   <= job_i.cls;
    end
    if (s2_en) begin
      out_q.box_x     <= (x_prod[31:24] != 8'd0) ? 16'hffff : x_prod[23:8];
      out_q.box_y     <= (y_prod[31:24] != 8'd0) ? 16'hffff : y_prod[23:8];
      out_q.box_w     <= w_q;
      out_q.box_h     <= h_q;
      out_q.box_score <= score_q;
      out_q.box_class <= cls_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
